// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top module of the rectangle fill engine.
// The using module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define PBRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PBRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/pbrf_pkg.sv =====
// Package of the rectangle fill engine: item types, configuration bundle,
// command and register codes, and the column/word helper functions.
// No dependencies.
package pbrf_pkg;

  localparam int COL_W   = 11;
  localparam int ROW_W   = 11;
  localparam int PITCH_W = 12;
  localparam int ADDR_W  = 25;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 24;

  localparam logic [1:0] MODE_PLOT    = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;

  localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_PIXEL_FORMAT = 3'd2;
  localparam logic [CIDX_W-1:0] REG_PEN_COLOR    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_FRAME_BASE   = 3'd4;

  localparam logic FMT_1BPP  = 1'b0;
  localparam logic FMT_24BPP = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [11:0] x_first;
    logic signed [11:0] y_first;
    logic signed [11:0] x_second;
    logic signed [11:0] y_second;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] word_address;
    logic [31:0]       write_data;
    logic [31:0]       bit_mask;
    logic              last_write;
  } out_item_t;

  // Settled configuration: dimensions already saturated, row pitch in words.
  typedef struct packed {
    logic [11:0]        width;
    logic [11:0]        height;
    logic               fmt;
    logic [23:0]        pen;
    logic [23:0]        base;
    logic [PITCH_W-1:0] pitch;
  } cfg_t;

  // Word index within a row that holds the first byte of a column.
  function automatic logic [COL_W-1:0] first_word(logic fmt, logic [COL_W-1:0] col);
    logic [COL_W+1:0] b;
    b = {2'b00, col} + {1'b0, col, 1'b0};
    return (fmt == FMT_24BPP) ? b[COL_W+1:2] : {5'd0, col[COL_W-1:5]};
  endfunction

  // Word index within a row that holds the last byte of a column.
  function automatic logic [COL_W-1:0] last_word(logic fmt, logic [COL_W-1:0] col);
    logic [COL_W+1:0] b;
    b = {2'b00, col} + {1'b0, col, 1'b0} + (COL_W+2)'(2);
    return (fmt == FMT_24BPP) ? b[COL_W+1:2] : {5'd0, col[COL_W-1:5]};
  endfunction

  // Bit of the word for a pixel: bytes in address order, MSB first in a byte.
  function automatic logic [31:0] pixel_bit(logic [4:0] x);
    return 32'd1 << {x[4:3], ~x[2:0]};
  endfunction

  // Residue modulo three by summing base-four digits.
  function automatic logic [1:0] mod3(logic [COL_W-1:0] v);
    logic [4:0] s;
    logic [2:0] s2;
    s  = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[10]);
    s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (s2 >= 3'd6) begin
      s2 = s2 - 3'd6;
    end else if (s2 >= 3'd3) begin
      s2 = s2 - 3'd3;
    end
    return s2[1:0];
  endfunction

endpackage

// ===== rtl/pbrf_cfg.sv =====
// Configuration registers of the rectangle fill engine, with saturation of
// the image size and the derived row pitch. Depends on pbrf_pkg.
module pbrf_cfg #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_i,
  input  logic [pbrf_pkg::CIDX_W-1:0]  index_i,
  input  logic [pbrf_pkg::CDAT_W-1:0]  data_i,
  output pbrf_pkg::cfg_t               cfg_o
);

  function automatic logic [11:0] sat_dim(logic [11:0] v, int max);
    if (v == 12'd0) begin
      return 12'd1;
    end
    if ({20'd0, v} > 32'(max)) begin
      return 12'(max);
    end
    return v;
  endfunction

  function automatic logic [pbrf_pkg::PITCH_W-1:0] pitch_of(logic [11:0] w, logic fmt);
    logic [16:0] bits;
    bits = (fmt == pbrf_pkg::FMT_24BPP) ? ({1'b0, w, 4'd0} + {2'b00, w, 3'd0})
                                        : {5'd0, w};
    bits = bits + 17'd31;
    return bits[16:5];
  endfunction

  localparam logic [11:0] RstWidth  = sat_dim(12'd640, MAX_WIDTH);
  localparam logic [11:0] RstHeight = sat_dim(12'd480, MAX_HEIGHT);

  pbrf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (index_i)
        pbrf_pkg::REG_IMAGE_WIDTH:  cfg_d.width  = sat_dim(data_i[11:0], MAX_WIDTH);
        pbrf_pkg::REG_IMAGE_HEIGHT: cfg_d.height = sat_dim(data_i[11:0], MAX_HEIGHT);
        pbrf_pkg::REG_PIXEL_FORMAT: cfg_d.fmt    = data_i[0];
        pbrf_pkg::REG_PEN_COLOR:    cfg_d.pen    = data_i;
        pbrf_pkg::REG_FRAME_BASE:   cfg_d.base   = data_i;
        default: ;
      endcase
    end
    // The pitch follows the new width and format at the same edge.
    cfg_d.pitch = pitch_of(cfg_d.width, cfg_d.fmt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= RstWidth;
      cfg_q.height <= RstHeight;
      cfg_q.fmt    <= pbrf_pkg::FMT_1BPP;
      cfg_q.pen    <= '0;
      cfg_q.base   <= '0;
      cfg_q.pitch  <= pitch_of(RstWidth, pbrf_pkg::FMT_1BPP);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pbrf_core.sv =====
// Command decode, fill sweep state and word/mask generation of the
// rectangle fill engine. Depends on pbrf_pkg.
module pbrf_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  pbrf_pkg::in_item_t  item_i,
  input  pbrf_pkg::cfg_t      cfg_i,
  output logic                res_valid_o,
  output pbrf_pkg::out_item_t res_o
);

  localparam int CW = pbrf_pkg::COL_W;
  localparam int RW = pbrf_pkg::ROW_W;
  localparam int AW = pbrf_pkg::ADDR_W;

  logic          active_q, active_d;
  logic [RW-1:0] row_q, row_d, bottom_q, bottom_d;
  logic [CW-1:0] left_q, left_d, right_q, right_d, word_q, word_d;
  logic [AW-1:0] rstart_q, rstart_d;

  // Sign-extended corners and zero-extended image size.
  logic signed [12:0] x1s, y1s, x2s, y2s, ws, hs;
  assign x1s = 13'(item_i.x_first);
  assign y1s = 13'(item_i.y_first);
  assign x2s = 13'(item_i.x_second);
  assign y2s = 13'(item_i.y_second);
  assign ws  = $signed({1'b0, cfg_i.width});
  assign hs  = $signed({1'b0, cfg_i.height});

  // Plot.
  logic        plot_hit;
  logic [31:0] plot_mask;
  logic [22:0] plot_prod;
  logic [AW-1:0] plot_addr;
  assign plot_hit  = (cfg_i.fmt == pbrf_pkg::FMT_1BPP) && !x1s[12] && (x1s < ws)
                     && !y1s[12] && (y1s < hs);
  assign plot_mask = pbrf_pkg::pixel_bit(item_i.x_first[4:0]);
  assign plot_prod = 23'(item_i.y_first[10:0]) * 23'(cfg_i.pitch);
  assign plot_addr = AW'(cfg_i.base) + AW'(plot_prod) + AW'(item_i.x_first[10:5]);

  // Rectangle clipping.
  logic signed [12:0] ls, ts, rs, bs;
  logic          rect_empty;
  logic [22:0]   load_prod;
  logic [AW-1:0] load_addr;
  assign ls = x1s[12] ? 13'sd0 : x1s;
  assign ts = y1s[12] ? 13'sd0 : y1s;
  assign rs = (x2s >= ws) ? (ws - 13'sd1) : x2s;
  assign bs = (y2s >= hs) ? (hs - 13'sd1) : y2s;
  assign rect_empty = (ls > rs) || (ts > bs);
  assign load_prod  = 23'(ts[10:0]) * 23'(cfg_i.pitch);
  assign load_addr  = AW'(cfg_i.base) + AW'(load_prod);

  // Word of the sweep.
  logic [31:0] adv_mask, adv_data;
  logic        row_end, last;
  logic [12:0] lo_b, hi_b;
  logic [1:0]  ph0;
  assign lo_b = {2'b00, left_q} + {1'b0, left_q, 1'b0};
  assign hi_b = {2'b00, right_q} + {1'b0, right_q, 1'b0} + 13'd2;
  assign ph0  = pbrf_pkg::mod3(word_q);

  always_comb begin
    logic [15:0] x;
    logic [4:0]  pos;
    logic [12:0] a;
    logic [2:0]  ph;
    logic [7:0]  c;
    adv_mask = '0;
    adv_data = '0;
    if (cfg_i.fmt == pbrf_pkg::FMT_1BPP) begin
      for (int i = 0; i < 32; i++) begin
        pos = 5'(i);
        x   = {word_q, pos};
        if ((x >= {5'd0, left_q}) && (x <= {5'd0, right_q})) begin
          adv_mask[{pos[4:3], ~pos[2:0]}] = 1'b1;
        end
      end
      adv_data = (cfg_i.pen != 24'd0) ? adv_mask : 32'd0;
    end else begin
      // Byte offsets from the left edge are a multiple of three, so the
      // colour phase of a byte is its address modulo three.
      for (int i = 0; i < 4; i++) begin
        a  = {word_q, 2'(i)};
        ph = 3'(ph0) + 3'(i);
        if (ph >= 3'd3) begin
          ph = ph - 3'd3;
        end
        unique case (ph)
          3'd0:    c = cfg_i.pen[7:0];
          3'd1:    c = cfg_i.pen[15:8];
          default: c = cfg_i.pen[23:16];
        endcase
        if ((a >= lo_b) && (a <= hi_b)) begin
          adv_mask[8*i +: 8] = 8'hFF;
          adv_data[8*i +: 8] = c;
        end
      end
    end
  end

  assign row_end = word_q >= pbrf_pkg::last_word(cfg_i.fmt, right_q);
  assign last    = row_end && (row_q >= bottom_q);

  always_comb begin
    active_d    = active_q;
    row_d       = row_q;
    bottom_d    = bottom_q;
    left_d      = left_q;
    right_d     = right_q;
    word_d      = word_q;
    rstart_d    = rstart_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (item_i.mode)
      pbrf_pkg::MODE_PLOT: begin
        res_valid_o        = plot_hit;
        res_o.word_address = plot_addr;
        res_o.write_data   = (cfg_i.pen != 24'd0) ? plot_mask : 32'd0;
        res_o.bit_mask     = plot_mask;
        res_o.last_write   = 1'b1;
      end
      pbrf_pkg::MODE_LOAD: begin
        if (rect_empty) begin
          active_d = 1'b0;
        end else begin
          active_d = 1'b1;
          left_d   = ls[CW-1:0];
          right_d  = rs[CW-1:0];
          row_d    = ts[RW-1:0];
          bottom_d = bs[RW-1:0];
          word_d   = pbrf_pkg::first_word(cfg_i.fmt, ls[CW-1:0]);
          rstart_d = load_addr;
        end
      end
      pbrf_pkg::MODE_ADVANCE: begin
        res_valid_o        = active_q;
        res_o.word_address = rstart_q + AW'(word_q);
        res_o.write_data   = adv_data;
        res_o.bit_mask     = adv_mask;
        res_o.last_write   = last;
        if (active_q) begin
          if (last) begin
            active_d = 1'b0;
          end else if (row_end) begin
            row_d    = row_q + RW'(1);
            rstart_d = rstart_q + AW'(cfg_i.pitch);
            word_d   = pbrf_pkg::first_word(cfg_i.fmt, left_q);
          end else begin
            word_d = word_q + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      row_q    <= '0;
      bottom_q <= '0;
      left_q   <= '0;
      right_q  <= '0;
      word_q   <= '0;
      rstart_q <= '0;
    end else if (fire_i) begin
      active_q <= active_d;
      row_q    <= row_d;
      bottom_q <= bottom_d;
      left_q   <= left_d;
      right_q  <= right_d;
      word_q   <= word_d;
      rstart_q <= rstart_d;
    end
  end

endmodule

// ===== rtl/packed_bitmap_rect_fill.sv =====
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   in_item_i (pbrf_pkg::in_item_t)
// out       output     out_valid_o/out_ready_i out_item_o (pbrf_pkg::out_item_t)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item is held in the input register and is then decoded, swept and
// written to the result register, so one item per cycle while the output is not stalled.
// The cycle limit is the sweep state update, which the next advance reads.
// Reset clears the handshake valids and the sweep state; configuration
// returns to its reset values. When the result waits, one further item is
// held in the input register; configuration writes are always taken.
// Depends on pbrf_pkg, pbrf_cfg, pbrf_core and assert_macros.svh.
`include "assert_macros.svh"

module packed_bitmap_rect_fill #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pbrf_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pbrf_pkg::out_item_t          out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pbrf_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [pbrf_pkg::CDAT_W-1:0]  cfg_data_i
);

  pbrf_pkg::cfg_t      cfg;
  pbrf_pkg::in_item_t  in_item_q;
  pbrf_pkg::out_item_t out_item_q, res;
  logic in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic advance, in_take, res_valid;

  assign cfg_ready_o = 1'b1;

  pbrf_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i),
    .index_i(cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  pbrf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .item_i     (in_item_q),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `PBRF_ASSERT(a_stall_cause, !in_ready_o |-> (out_valid_o && !out_ready_i), "input stalled without an output stall")
  `PBRF_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(in_valid_q), "result appeared without a held item")
  `PBRF_ASSERT(a_data_in_mask, out_valid_o |-> ((out_item_o.write_data & ~out_item_o.bit_mask) == 32'd0), "data bits set outside the mask")
  `PBRF_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!out_valid_o && in_ready_o), "handshake not idle in reset")

endmodule
